// ----- hw/rtl/hsc_pkg.sv -----
// package for the hue-stable rgb highlight clip pipeline
// holds pixel payload types, channel codes and the divider stage types
// no dependencies
package hsc_pkg;

  // channel and arithmetic widths
  localparam int unsigned CH_W   = 24;            // signed input channel
  localparam int unsigned VAL_W  = 23;            // clamped / clipped channel
  localparam int unsigned PROD_W = 2 * VAL_W;     // span * offset product

  // restoring divider: one quotient bit per step, a few steps per stage
  localparam int unsigned DIV_STEPS  = 4;
  localparam int unsigned DIV_STAGES = (VAL_W + DIV_STEPS - 1) / DIV_STEPS;
  localparam int unsigned DIV_LAST   = VAL_W - (DIV_STAGES - 1) * DIV_STEPS;

  // channel codes
  typedef enum logic [1:0] {
    CH_RED   = 2'd0,
    CH_GREEN = 2'd1,
    CH_BLUE  = 2'd2
  } chan_e;

  // input pixel transfer
  typedef struct packed {
    logic signed [CH_W-1:0] red_in;
    logic signed [CH_W-1:0] green_in;
    logic signed [CH_W-1:0] blue_in;
  } pix_in_t;

  // output pixel transfer
  typedef struct packed {
    logic [VAL_W-1:0] red_out;
    logic [VAL_W-1:0] green_out;
    logic [VAL_W-1:0] blue_out;
  } pix_out_t;

  // values that ride along with the division
  typedef struct packed {
    logic [VAL_W-1:0] mx;
    logic [VAL_W-1:0] mn;
    chan_e            hi;
    chan_e            lo;
    logic             eq;
  } side_t;

  // divider stage payload
  typedef struct packed {
    logic [VAL_W-1:0] rem;
    logic [VAL_W-1:0] num_lo;
    logic [VAL_W-1:0] quo;
    logic [VAL_W-1:0] den;
    side_t            side;
  } div_t;

endpackage

// ----- hw/rtl/hsc_div_stage.sv -----
// one registered stage of the pipelined restoring divider
// resolves STEPS quotient bits per stage; uses hsc_pkg
module hsc_div_stage #(
  parameter int unsigned STEPS = 4
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           ready_o,
  input  hsc_pkg::div_t  data_i,
  output logic           valid_o,
  input  logic           ready_i,
  output hsc_pkg::div_t  data_o
);

  logic          valid_q;
  hsc_pkg::div_t data_d, data_q;

  // stage takes a new item when empty or when its content moves on
  assign ready_o = !valid_q || ready_i;

  // compare and subtract, one quotient bit per step
  always_comb begin
    logic [hsc_pkg::VAL_W:0] trial;
    data_d = data_i;
    trial  = '0;
    for (int k = 0; k < STEPS; k++) begin
      trial = {data_d.rem, data_d.num_lo[hsc_pkg::VAL_W-1]};
      data_d.num_lo = {data_d.num_lo[hsc_pkg::VAL_W-2:0], 1'b0};
      if (trial >= {1'b0, data_d.den}) begin
        data_d.rem = hsc_pkg::VAL_W'(trial - {1'b0, data_d.den});
        data_d.quo = {data_d.quo[hsc_pkg::VAL_W-2:0], 1'b1};
      end else begin
        data_d.rem = trial[hsc_pkg::VAL_W-1:0];
        data_d.quo = {data_d.quo[hsc_pkg::VAL_W-2:0], 1'b0};
      end
    end
  end

  // valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ----- hw/rtl/hue_stable_rgb_highlight_clip_top.sv -----
// top level of the hue-stable rgb highlight clip pipeline
// clamp, sort, clip, multiply, pipelined divide, reassemble; uses hsc_pkg, hsc_div_stage
//
//   channel | direction | handshake             | payload
//   in      | input     | in_valid_i/in_ready_o | in_data_i  (3 x 24-bit signed)
//   out     | output    | out_valid_o/out_ready_i | out_data_o (3 x 23-bit unsigned)
//   cfg     | input     | cfg_we_i, no wait     | cfg_data_i (23-bit clip level)
//
// one pixel per clock sustained while out_ready_i stays high; the registered stages in order are
// sort, clip, multiply, 6 divider stages, output register; the divider sets the depth
// reset empties every stage and loads the clip level with 1.0
// each stage holds its item while the next one is full and blocked; empty stages
// fill during a stall, so input is taken while a result waits at the output
module hue_stable_rgb_highlight_clip_top #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  hsc_pkg::pix_in_t           in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output hsc_pkg::pix_out_t          out_data_o,
  input  logic                       cfg_we_i,
  input  logic [hsc_pkg::VAL_W-1:0]  cfg_data_i
);

  localparam int unsigned VAL_W  = hsc_pkg::VAL_W;
  localparam int unsigned PROD_W = hsc_pkg::PROD_W;
  localparam int unsigned NSTG   = hsc_pkg::DIV_STAGES;
  localparam logic [VAL_W-1:0] CLIP_RST = (FRAC_BITS >= VAL_W) ? {VAL_W{1'b1}}
                                          : VAL_W'(64'd1 << FRAC_BITS);

  typedef struct packed {
    logic [VAL_W-1:0] hv;
    logic [VAL_W-1:0] mv;
    logic [VAL_W-1:0] lv;
    hsc_pkg::chan_e   hi;
    hsc_pkg::chan_e   lo;
  } sort_t;

  typedef struct packed {
    hsc_pkg::side_t   side;
    logic [VAL_W-1:0] span;
    logic [VAL_W-1:0] dmid;
    logic [VAL_W-1:0] den;
  } clip_t;

  typedef struct packed {
    hsc_pkg::side_t    side;
    logic [PROD_W-1:0] num;
    logic [VAL_W-1:0]  den;
  } prod_t;

  logic [VAL_W-1:0] clip_q;
  logic             s1_v_q, s2_v_q, s3_v_q, out_v_q;
  logic             s1_ld, s2_ld, s3_ld, out_ld;
  sort_t            s1_d, s1_q;
  clip_t            s2_d, s2_q;
  prod_t            s3_d, s3_q;
  hsc_pkg::pix_out_t out_d, out_q;

  logic          dv_valid [NSTG+1];
  logic          dv_ready [NSTG+1];
  hsc_pkg::div_t dv_data  [NSTG+1];

  // clip level register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clip_q <= CLIP_RST;
    end else if (cfg_we_i) begin
      clip_q <= cfg_data_i;
    end
  end

  // stage load enables, ready ripples back from the output register
  assign out_ld     = !out_v_q || out_ready_i;
  assign s3_ld      = !s3_v_q || dv_ready[0];
  assign s2_ld      = !s2_v_q || s3_ld;
  assign s1_ld      = !s1_v_q || s2_ld;
  assign in_ready_o = s1_ld;

  // stage 1: zero each channel whose bit VAL_W is set, order channels into high, middle, low
  always_comb begin
    logic [VAL_W-1:0] tv;
    hsc_pkg::chan_e   mi, ti;
    tv      = '0;
    ti      = hsc_pkg::CH_RED;
    s1_d.hv = in_data_i.red_in[VAL_W]   ? '0 : in_data_i.red_in[VAL_W-1:0];
    s1_d.mv = in_data_i.green_in[VAL_W] ? '0 : in_data_i.green_in[VAL_W-1:0];
    s1_d.lv = in_data_i.blue_in[VAL_W]  ? '0 : in_data_i.blue_in[VAL_W-1:0];
    s1_d.hi = hsc_pkg::CH_RED;
    mi      = hsc_pkg::CH_GREEN;
    s1_d.lo = hsc_pkg::CH_BLUE;
    if (s1_d.mv > s1_d.hv) begin
      tv = s1_d.hv; s1_d.hv = s1_d.mv; s1_d.mv = tv;
      ti = s1_d.hi; s1_d.hi = mi;      mi      = ti;
    end
    if (s1_d.lv > s1_d.mv) begin
      tv = s1_d.mv; s1_d.mv = s1_d.lv; s1_d.lv = tv;
      ti = mi;      mi      = s1_d.lo; s1_d.lo = ti;
    end
    if (s1_d.mv > s1_d.hv) begin
      tv = s1_d.hv; s1_d.hv = s1_d.mv; s1_d.mv = tv;
      ti = s1_d.hi; s1_d.hi = mi;      mi      = ti;
    end
  end

  // stage 2: clip high and low, form span, offset and divisor
  always_comb begin
    s2_d.side.mx = (s1_q.hv > clip_q) ? clip_q : s1_q.hv;
    s2_d.side.mn = (s1_q.lv > clip_q) ? clip_q : s1_q.lv;
    s2_d.side.hi = s1_q.hi;
    s2_d.side.lo = s1_q.lo;
    s2_d.side.eq = (s1_q.mv == s1_q.lv);
    s2_d.span    = s2_d.side.mx - s2_d.side.mn;
    s2_d.dmid    = s1_q.mv - s1_q.lv;
    s2_d.den     = s1_q.hv - s1_q.lv;
  end

  // stage 3: exact product of span and offset
  always_comb begin
    s3_d.side = s2_q.side;
    s3_d.num  = {{(PROD_W-VAL_W){1'b0}}, s2_q.span} * {{(PROD_W-VAL_W){1'b0}}, s2_q.dmid};
    s3_d.den  = s2_q.den;
  end

  // stage registers ahead of the divider
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
    end else begin
      if (s1_ld) s1_v_q <= in_valid_i;
      if (s2_ld) s2_v_q <= s1_v_q;
      if (s3_ld) s3_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ld && in_valid_i) s1_q <= s1_d;
    if (s2_ld && s1_v_q)     s2_q <= s2_d;
    if (s3_ld && s2_v_q)     s3_q <= s3_d;
  end

  // divider input: upper product half is already below the divisor
  assign dv_valid[0]       = s3_v_q;
  assign dv_data[0].rem    = s3_q.num[PROD_W-1:VAL_W];
  assign dv_data[0].num_lo = s3_q.num[VAL_W-1:0];
  assign dv_data[0].quo    = '0;
  assign dv_data[0].den    = s3_q.den;
  assign dv_data[0].side   = s3_q.side;

  // pipelined restoring divider
  for (genvar g = 0; g < NSTG; g++) begin : g_div
    hsc_div_stage #(
      .STEPS ((g == NSTG - 1) ? hsc_pkg::DIV_LAST : hsc_pkg::DIV_STEPS)
    ) u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (dv_valid[g]),
      .ready_o (dv_ready[g]),
      .data_i  (dv_data[g]),
      .valid_o (dv_valid[g+1]),
      .ready_i (dv_ready[g+1]),
      .data_o  (dv_data[g+1])
    );
  end
  assign dv_ready[NSTG] = out_ld;

  // pick the value for one channel by its rank
  function automatic logic [VAL_W-1:0] pick(hsc_pkg::chan_e c, hsc_pkg::side_t s,
                                             logic [VAL_W-1:0] mid);
    logic [VAL_W-1:0] r;
    if (c == s.hi) begin
      r = s.mx;
    end else if (c == s.lo) begin
      r = s.mn;
    end else begin
      r = mid;
    end
    return r;
  endfunction

  // final stage: rebuild the middle channel and put channels back in place
  always_comb begin
    hsc_pkg::side_t   s;
    logic [VAL_W-1:0] mid;
    s   = dv_data[NSTG].side;
    mid = s.mn + (s.eq ? '0 : dv_data[NSTG].quo);
    out_d.red_out   = pick(hsc_pkg::CH_RED,   s, mid);
    out_d.green_out = pick(hsc_pkg::CH_GREEN, s, mid);
    out_d.blue_out  = pick(hsc_pkg::CH_BLUE,  s, mid);
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (out_ld) begin
      out_v_q <= dv_valid[NSTG];
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ld && dv_valid[NSTG]) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

endmodule

// ----- hw/rtl/hsc_checker.sv -----
// port-level checks for the hue-stable rgb highlight clip top
// tracks clip level and items in flight from the ports; uses hsc_pkg, bound to the top
module hsc_checker #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  logic                       in_ready_o,
  input  logic                       out_valid_o,
  input  logic                       out_ready_i,
  input  hsc_pkg::pix_out_t          out_data_o,
  input  logic                       cfg_we_i,
  input  logic [hsc_pkg::VAL_W-1:0]  cfg_data_i
);

  localparam int unsigned VAL_W = hsc_pkg::VAL_W;
  localparam logic [VAL_W-1:0] CLIP_RST = (FRAC_BITS >= VAL_W) ? {VAL_W{1'b1}}
                                          : VAL_W'(64'd1 << FRAC_BITS);

  logic [VAL_W-1:0] clip_q;
  logic [4:0]       cnt_q, cnt_d;
  logic             in_xfer, out_xfer;

  assign in_xfer  = in_valid_i && in_ready_o;
  assign out_xfer = out_valid_o && out_ready_i;

  // shadow of the clip level and count of items in flight
  always_comb begin
    cnt_d = cnt_q;
    if (in_xfer && !out_xfer) cnt_d = cnt_q + 5'd1;
    if (!in_xfer && out_xfer) cnt_d = cnt_q - 5'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clip_q <= CLIP_RST;
      cnt_q  <= '0;
    end else begin
      if (cfg_we_i) clip_q <= cfg_data_i;
      cnt_q <= cnt_d;
    end
  end

  // a waiting result holds until its transfer
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output changed while stalled");

  // no result without an item in flight
  a_no_extra: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> cnt_q != 5'd0)
    else $error("result without matching input");

  // input only blocks when a result is waiting
  a_no_idle_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input blocked with empty output");

  // every channel stays at or below the clip level
  a_clip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.red_out <= clip_q && out_data_o.green_out <= clip_q
                    && out_data_o.blue_out <= clip_q)
    else $error("output above clip level");

endmodule

bind hue_stable_rgb_highlight_clip_top hsc_checker #(
  .FRAC_BITS (FRAC_BITS)
) u_hsc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o),
  .cfg_we_i    (cfg_we_i),
  .cfg_data_i  (cfg_data_i)
);
